// ----- rtl/core/format_string_text_formatter_core_defines.svh -----
// Assertion macros shared by the formatter RTL.
// Each macro expects clk and rst in scope at the point of use.
`ifndef FORMAT_STRING_TEXT_FORMATTER_CORE_DEFINES_SVH
`define FORMAT_STRING_TEXT_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FSF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fsf_pkg.sv -----
// Shared types, constants and helpers for the text formatter core.
// No dependencies.
package fsf_pkg;

  localparam int FRAC_BITS_DEF = 32;
  localparam int CFG_IDX_W     = 8;
  localparam int NUM_W         = 36;

  localparam logic [CFG_IDX_W-1:0] REG_FRAC_DIGITS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_CUTOFF = 8'd1;

  localparam logic [3:0]  FRAC_DIGITS_RST = 4'd8;
  localparam logic [3:0]  FRAC_DIGITS_MAX = 4'd8;
  localparam logic [31:0] FRAC_CUTOFF_RST = 32'd4294;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_BTICK = 8'h60;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_S     = 8'h73;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_END  = 2'd1,
    KIND_OOT  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_PERCENT,
    MODE_WAIT_D,
    MODE_WAIT_F,
    MODE_WAIT_C,
    MODE_WAIT_S
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PCT,
    S_MAIN,
    S_SIGN,
    S_SCAN,
    S_DIG,
    S_DOUT,
    S_DOT,
    S_FRAC,
    S_FCHK
  } state_t;

  typedef enum logic {
    ALU_SUB,
    ALU_MUL10
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [NUM_W-1:0] a;
    logic [NUM_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [NUM_W-1:0] res;
    logic             borrow;
  } alu_rsp_t;

  typedef struct packed {
    logic [3:0]  frac_digits;
    logic [31:0] frac_cutoff;
  } cfg_t;

  function automatic logic [NUM_W-1:0] pow10(input logic [3:0] p);
    logic [NUM_W-1:0] v;
    case (p)
      4'd0:    v = 36'd1;
      4'd1:    v = 36'd10;
      4'd2:    v = 36'd100;
      4'd3:    v = 36'd1000;
      4'd4:    v = 36'd10000;
      4'd5:    v = 36'd100000;
      4'd6:    v = 36'd1000000;
      4'd7:    v = 36'd10000000;
      4'd8:    v = 36'd100000000;
      4'd9:    v = 36'd1000000000;
      default: v = 36'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/fsf_alu.sv -----
// Shared arithmetic unit: subtract with borrow, or multiply by ten.
// Depends on fsf_pkg.
module fsf_alu (
  input  fsf_pkg::alu_req_t req,
  output fsf_pkg::alu_rsp_t rsp
);
  import fsf_pkg::*;

  logic [NUM_W:0]   diff;
  logic [NUM_W-1:0] mul10;

  assign diff  = {1'b0, req.a} - {1'b0, req.b};
  assign mul10 = (req.a << 3) + (req.a << 1);

  always_comb begin
    rsp.borrow = diff[NUM_W];
    case (req.op)
      ALU_SUB:   rsp.res = diff[NUM_W-1:0];
      ALU_MUL10: rsp.res = mul10;
      default:   rsp.res = diff[NUM_W-1:0];
    endcase
  end

endmodule

// ----- rtl/core/fsf_ctrl.sv -----
// Format parser, digit sequencer and output register of the formatter.
// Depends on fsf_pkg, the defines header and an external fsf_alu.
`include "format_string_text_formatter_core_defines.svh"
module fsf_ctrl #(
  parameter int FRAC_BITS = fsf_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  fsf_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic [7:0]        fmt_byte,
  input  logic [63:0]       arg_u,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_byte,
  output logic [15:0]       directive_count,
  output logic              last,
  output fsf_pkg::alu_req_t alu_req,
  input  fsf_pkg::alu_rsp_t alu_rsp
);
  import fsf_pkg::*;

  localparam int SH_HI    = FRAC_BITS + 32;
  localparam int FRAC_PAD = 32 - FRAC_BITS;

  state_t state, state_next;
  mode_t  mode;
  logic [15:0] used, snap;

  // pending single results
  kind_t      p_kind;
  logic [7:0] p_byte;
  logic       p_main;

  // number datapath
  logic [31:0] num, frac;
  logic [3:0]  pos, dacc, fcnt, digit;
  logic [1:0]  k;
  logic        is_fix;

  logic acc, waiting, can_emit;
  logic [3:0] lim;
  logic gt, dot_last, flast;

  // decode of an accepted item
  logic  d_pct, d_main, d_go, d_fix, d_neg, is_dir;
  kind_t d_kind;
  logic [7:0]  d_byte;
  mode_t d_mode, dir_mode;
  logic [15:0] d_used;
  logic [31:0] int_mag, fix_int, fix_frac;
  logic [63:0] fix_mag;
  logic        clamp;

  // emit
  logic       emit, e_last;
  kind_t      e_kind;
  logic [7:0] e_byte;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign can_emit = !out_valid || out_ready;
  assign waiting  = (mode == MODE_WAIT_D) || (mode == MODE_WAIT_F) ||
                    (mode == MODE_WAIT_C) || (mode == MODE_WAIT_S);
  assign lim      = (cfg.frac_digits > FRAC_DIGITS_MAX) ? FRAC_DIGITS_MAX : cfg.frac_digits;
  assign gt       = alu_rsp.borrow;   // cutoff - frac borrows when frac > cutoff
  assign dot_last = (lim == 4'd0) || !gt;
  assign flast    = (fcnt == lim) || !gt;

  assign int_mag  = arg_u[31] ? (~arg_u[31:0] + 32'd1) : arg_u[31:0];
  assign fix_mag  = arg_u[63] ? (~arg_u + 64'd1) : arg_u;
  assign clamp    = |(fix_mag >> SH_HI);
  assign fix_int  = clamp ? 32'hFFFF_FFFF : 32'(fix_mag >> FRAC_BITS);
  assign fix_frac = clamp ? 32'({64{1'b1}} << FRAC_PAD) : 32'(fix_mag << FRAC_PAD);

  always_comb begin
    is_dir   = 1'b1;
    dir_mode = MODE_NORMAL;
    case (fmt_byte)
      CH_D:    dir_mode = MODE_WAIT_D;
      CH_F:    dir_mode = MODE_WAIT_F;
      CH_C:    dir_mode = MODE_WAIT_C;
      CH_S:    dir_mode = MODE_WAIT_S;
      default: is_dir = 1'b0;
    endcase
  end

  always_comb begin
    d_pct  = 1'b0;
    d_main = 1'b0;
    d_go   = 1'b0;
    d_fix  = 1'b0;
    d_neg  = 1'b0;
    d_kind = KIND_TEXT;
    d_byte = CH_NUL;
    d_mode = mode;
    d_used = used;
    if (!action) begin
      if (waiting) begin
        d_main = 1'b1;
        d_kind = KIND_OOT;
      end else begin
        d_mode = MODE_NORMAL;
        if (mode == MODE_PERCENT && is_dir) begin
          d_mode = dir_mode;
          d_used = (used == 16'hFFFF) ? used : used + 16'd1;
        end else begin
          d_pct = (mode == MODE_PERCENT);
          if (fmt_byte == CH_NUL) begin
            d_main = 1'b1;
            d_kind = KIND_END;
            d_used = '0;
          end else if (fmt_byte == CH_PCT) begin
            d_mode = MODE_PERCENT;
          end else if (fmt_byte == CH_BTICK) begin
            d_main = 1'b1;
            d_byte = CH_APOS;
          end else begin
            d_main = 1'b1;
            d_byte = fmt_byte;
          end
        end
      end
    end else if (!waiting) begin
      d_main = 1'b1;
      d_kind = KIND_OOT;
    end else begin
      case (mode)
        MODE_WAIT_C: begin
          d_main = 1'b1;
          d_byte = arg_u[7:0];
          d_mode = MODE_NORMAL;
        end
        MODE_WAIT_S: begin
          if (arg_u[7:0] == CH_NUL) begin
            d_mode = MODE_NORMAL;
          end else begin
            d_main = 1'b1;
            d_byte = arg_u[7:0];
          end
        end
        MODE_WAIT_D: begin
          d_go   = 1'b1;
          d_neg  = arg_u[31];
          d_mode = MODE_NORMAL;
        end
        MODE_WAIT_F: begin
          d_go   = 1'b1;
          d_fix  = 1'b1;
          d_neg  = arg_u[63];
          d_mode = MODE_NORMAL;
        end
        default: ;
      endcase
    end
  end

  // shared unit request
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state)
      S_SCAN: begin
        alu_req.a = {4'd0, num};
        alu_req.b = pow10(pos);
      end
      S_DIG: begin
        alu_req.a = {4'd0, num};
        alu_req.b = pow10(pos) << k;
      end
      S_DOT, S_FCHK: begin
        alu_req.a = {4'd0, cfg.frac_cutoff};
        alu_req.b = {4'd0, frac};
      end
      S_FRAC: begin
        alu_req.op = ALU_MUL10;
        alu_req.a  = {4'd0, frac};
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (d_go)        state_next = d_neg ? S_SIGN : S_SCAN;
          else if (d_pct)  state_next = S_PCT;
          else if (d_main) state_next = S_MAIN;
        end
      end
      S_PCT:  if (can_emit) state_next = p_main ? S_MAIN : S_IDLE;
      S_MAIN: if (can_emit) state_next = S_IDLE;
      S_SIGN: if (can_emit) state_next = S_SCAN;
      S_SCAN: if (!(pos != 4'd0 && alu_rsp.borrow)) state_next = S_DIG;
      S_DIG:  if (k == 2'd0) state_next = S_DOUT;
      S_DOUT: begin
        if (can_emit) begin
          if (pos != 4'd0) state_next = S_DIG;
          else             state_next = is_fix ? S_DOT : S_IDLE;
        end
      end
      S_DOT:  if (can_emit) state_next = dot_last ? S_IDLE : S_FRAC;
      S_FRAC: state_next = S_FCHK;
      S_FCHK: if (can_emit) state_next = flast ? S_IDLE : S_FRAC;
      default: state_next = S_IDLE;
    endcase
  end

  // result produced this cycle
  always_comb begin
    emit   = 1'b0;
    e_kind = KIND_TEXT;
    e_byte = CH_NUL;
    e_last = 1'b0;
    case (state)
      S_PCT: begin
        emit   = can_emit;
        e_byte = CH_PCT;
        e_last = !p_main;
      end
      S_MAIN: begin
        emit   = can_emit;
        e_kind = p_kind;
        e_byte = p_byte;
        e_last = 1'b1;
      end
      S_SIGN: begin
        emit   = can_emit;
        e_byte = CH_MINUS;
      end
      S_DOUT: begin
        emit   = can_emit;
        e_byte = CH_ZERO + {4'd0, dacc};
        e_last = !is_fix && (pos == 4'd0);
      end
      S_DOT: begin
        emit   = can_emit;
        e_byte = CH_DOT;
        e_last = dot_last;
      end
      S_FCHK: begin
        emit   = can_emit;
        e_byte = CH_ZERO + {4'd0, digit};
        e_last = flast;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_NORMAL;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (acc) begin
        mode <= d_mode;
        used <= d_used;
      end
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind        <= e_kind;
      out_byte        <= e_byte;
      directive_count <= snap;
      last            <= e_last;
    end
    case (state)
      S_IDLE: begin
        if (acc) begin
          snap   <= used;
          p_kind <= d_kind;
          p_byte <= d_byte;
          p_main <= d_main;
          num    <= d_fix ? fix_int : int_mag;
          frac   <= fix_frac;
          is_fix <= d_fix;
          pos    <= 4'd9;
          fcnt   <= 4'd0;
        end
      end
      S_SCAN: begin
        if (pos != 4'd0 && alu_rsp.borrow) begin
          pos <= pos - 4'd1;
        end else begin
          k    <= 2'd3;
          dacc <= 4'd0;
        end
      end
      S_DIG: begin
        if (!alu_rsp.borrow) begin
          num     <= alu_rsp.res[31:0];
          dacc[k] <= 1'b1;
        end
        k <= k - 2'd1;
      end
      S_DOUT: begin
        if (can_emit && pos != 4'd0) begin
          pos  <= pos - 4'd1;
          k    <= 2'd3;
          dacc <= 4'd0;
        end
      end
      S_FRAC: begin
        frac  <= alu_rsp.res[31:0];
        digit <= alu_rsp.res[NUM_W-1:32];
        fcnt  <= fcnt + 4'd1;
      end
      default: ;
    endcase
  end

  `FSF_ASSERT_SAME(a_digit_range, state == S_DOUT, dacc <= 4'd9, "decimal digit above nine")
  `FSF_ASSERT_NEXT(a_dig_flow, state == S_DIG, state == S_DIG || state == S_DOUT, "digit loop left early")
  `FSF_ASSERT_NEXT(a_count_busy, state != S_IDLE, $stable(used), "count moved while busy")
  `FSF_ASSERT_NEXT(a_int_done, acc && action && mode == MODE_WAIT_D, mode == MODE_NORMAL,
                   "int argument did not end directive")

endmodule

// ----- rtl/core/format_string_text_formatter_core.sv -----
// Text formatter core: config registers, parser/sequencer and shared ALU.
// A text byte or flag is held in a pending register, then registered onto the output once it is free.
// Numbers: a leading-zero scan, then each integer digit by conditional subtraction
// and each fraction digit by multiply-by-ten, both on the shared subtract/multiply-by-ten unit.
// One item in flight.
// Sync reset: parser to normal text, count 0, frac_digits 8, cutoff 4294.
module format_string_text_formatter_core #(
  parameter int FRAC_BITS = fsf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [7:0]                    fmt_byte,
  input  logic signed [63:0]            arg_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_byte,
  output logic [15:0]                   directive_count,
  output logic                          last
);
  import fsf_pkg::*;

  cfg_t     cfg;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frac_digits <= FRAC_DIGITS_RST;
      cfg.frac_cutoff <= FRAC_CUTOFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAC_DIGITS: cfg.frac_digits <= cfg_data[3:0];
        REG_FRAC_CUTOFF: cfg.frac_cutoff <= cfg_data;
        default: ;
      endcase
    end
  end

  fsf_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  fsf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .fmt_byte        (fmt_byte),
    .arg_u           (64'(arg_value)),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .directive_count (directive_count),
    .last            (last),
    .alu_req         (alu_req),
    .alu_rsp         (alu_rsp)
  );

endmodule
